### design/cfa_pkg.sv
// shared types and constants for the int32 constant fold alu
package cfa_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DATA_W + 1);

	typedef enum logic [3:0] {
		OP_SUB = 4'd0,
		OP_DIV = 4'd1,
		OP_MOD = 4'd2,
		OP_POW = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_SHL = 4'd7,
		OP_SHR = 4'd8,
		OP_NOT = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_UNDEF = 2'd1,
		STAT_OVER  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic start;
		logic is_pow;
	} iter_cmd_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              over;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] acc;
	} iter_res_t;

endpackage

### design/cfa_iter.sv
// shared iterative unit: restoring divide on magnitudes, or repeated multiply for power
module cfa_iter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfa_pkg::iter_cmd_t                 cmd,
	input  logic signed [cfa_pkg::DATA_W-1:0]  left,
	input  logic signed [cfa_pkg::DATA_W-1:0]  right,
	output cfa_pkg::iter_res_t                 res
);

	localparam int unsigned W = cfa_pkg::DATA_W;

	logic                      busy_q;
	logic                      done_q;
	logic                      over_q;
	logic                      pow_q;
	logic [cfa_pkg::CNT_W-1:0] cnt_q;
	// rem_q doubles as the power accumulator, dvd_q as the exponent, dsr_q as the base
	logic [W-1:0]              rem_q;
	logic [W-1:0]              dvd_q;
	logic [W-1:0]              dsr_q;

	logic [W:0]                shifted;
	logic [W:0]                diff;
	logic                      ge;
	logic signed [2*W-1:0]     prod;
	logic                      prod_fits;
	logic                      fin;
	logic [W-1:0]              left_mag;
	logic [W-1:0]              right_mag;

	always_comb begin
		shifted   = {rem_q, dvd_q[W-1]};
		ge        = shifted >= {1'b0, dsr_q};
		diff      = shifted - {1'b0, dsr_q};
		prod      = $signed(rem_q) * $signed(dsr_q);
		prod_fits = (prod[2*W-1:W-1] == '0) || (prod[2*W-1:W-1] == '1);
		left_mag  = left[W-1] ? (~left + 1'b1) : left;
		right_mag = right[W-1] ? (~right + 1'b1) : right;
		if (pow_q) begin
			fin = busy_q && (!prod_fits || dvd_q == W'(1));
		end else begin
			fin = busy_q && (cnt_q == cfa_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			over_q <= 1'b0;
			pow_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			over_q <= 1'b0;
			pow_q  <= cmd.is_pow;
			cnt_q  <= cfa_pkg::CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (pow_q && !prod_fits) begin
				over_q <= 1'b1;
			end
			if (fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.is_pow) begin
				rem_q <= W'(1);
				dvd_q <= right;
				dsr_q <= left;
			end else begin
				rem_q <= '0;
				dvd_q <= left_mag;
				dsr_q <= right_mag;
			end
		end else if (busy_q) begin
			if (pow_q) begin
				if (prod_fits) begin
					rem_q <= prod[W-1:0];
					dvd_q <= dvd_q - 1'b1;
				end
			end else begin
				rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
				dvd_q <= {dvd_q[W-2:0], ge};
			end
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.over = over_q;
	assign res.quo  = dvd_q;
	assign res.rem  = rem_q;
	assign res.acc  = rem_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("iter unit reports done while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q && !done_q)
		else $error("iter unit did not start");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !pow_q |-> cnt_q != '0)
		else $error("divide ran past its last quotient bit");

endmodule

### design/int32_constant_fold_alu.sv
// top level: int32 constant fold alu with sequencer and output register
//
// Folds one operation on two signed 32-bit constants per input word: sub, div,
// mod, pow, and, or, xor, shl, shr and not. Each result word carries the value
// and a status (ok, undefined, overflow); the value is zero unless status is ok.
// Input channel: in_valid/in_ready with operation, operands and undefined marks.
// Output channel: out_valid/out_ready with result_value and status.
// One word is in flight at a time. After acceptance, logic, shift, subtract and
// the special cases of power pass the execute state to the output register.
// Divide and remainder run the radix-2 restoring divider, one quotient bit per
// step, between decode and write-back. Power with a base other than -1, 0, 1
// takes one multiply per exponent step in the same shared unit, ending at the
// exponent or at the first overflow, so at most 32 multiplies.
// in_ready is high only while the sequencer is idle; a new word may be taken
// while the previous result still waits in the output register. When the
// receiver stalls, a finished result waits inside until the register frees.
// Reset (arst_n low) empties the sequencer and the output register.
module int32_constant_fold_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [3:0]                        operation,
	input  logic signed [cfa_pkg::DATA_W-1:0] left_value,
	input  logic signed [cfa_pkg::DATA_W-1:0] right_value,
	input  logic                              left_undefined,
	input  logic                              right_undefined,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cfa_pkg::DATA_W-1:0] result_value,
	output logic [1:0]                        status
);

	localparam int unsigned W = cfa_pkg::DATA_W;

	cfa_pkg::state_t    state_q;
	cfa_pkg::state_t    state_d;

	logic [3:0]         op_q;
	logic signed [W-1:0] l_q;
	logic signed [W-1:0] r_q;
	logic               lu_q;
	logic               ru_q;

	logic               out_valid_q;
	logic signed [W-1:0] value_q;
	cfa_pkg::stat_t     status_q;

	logic               out_free;
	logic               load_fast;
	logic               load_wait;
	logic               needs_iter;
	logic               iter_pow;
	logic signed [W-1:0] fast_val;
	cfa_pkg::stat_t     fast_stat;
	logic signed [W-1:0] wait_val;
	cfa_pkg::stat_t     wait_stat;
	logic [W:0]         sub_w;
	logic [2*W-1:0]     shl_w;
	logic               bad_shift;
	logic               neg;

	cfa_pkg::iter_cmd_t iter_cmd;
	cfa_pkg::iter_res_t iter_res;

	cfa_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (iter_cmd),
		.left   (l_q),
		.right  (r_q),
		.res    (iter_res)
	);

	assign out_free = !out_valid_q || out_ready;

	// combinational ops and the checks that decide undefined or overflow early
	always_comb begin
		fast_val   = '0;
		fast_stat  = cfa_pkg::STAT_OK;
		needs_iter = 1'b0;
		iter_pow   = 1'b0;
		sub_w      = {l_q[W-1], l_q} - {r_q[W-1], r_q};
		shl_w      = {{W{l_q[W-1]}}, l_q} << r_q[$clog2(W)-1:0];
		bad_shift  = r_q[W-1:$clog2(W)] != '0;
		if (op_q == cfa_pkg::OP_NOT) begin
			if (lu_q) begin
				fast_stat = cfa_pkg::STAT_UNDEF;
			end else begin
				fast_val = ~l_q;
			end
		end else if (op_q > cfa_pkg::OP_NOT) begin
			fast_stat = cfa_pkg::STAT_UNDEF;
		end else if (lu_q || ru_q) begin
			fast_stat = cfa_pkg::STAT_UNDEF;
		end else begin
			unique case (op_q)
				cfa_pkg::OP_SUB: begin
					if (sub_w[W] != sub_w[W-1]) begin
						fast_stat = cfa_pkg::STAT_OVER;
					end else begin
						fast_val = sub_w[W-1:0];
					end
				end
				cfa_pkg::OP_DIV, cfa_pkg::OP_MOD: begin
					if (r_q == '0) begin
						fast_stat = cfa_pkg::STAT_UNDEF;
					end else begin
						needs_iter = 1'b1;
					end
				end
				cfa_pkg::OP_POW: begin
					// trivial bases would loop for the whole exponent, fold them here
					if (r_q[W-1]) begin
						fast_stat = cfa_pkg::STAT_UNDEF;
					end else if (r_q == '0) begin
						fast_val = W'(1);
					end else if (l_q == '0) begin
						fast_val = '0;
					end else if (l_q == W'(1)) begin
						fast_val = W'(1);
					end else if (l_q == '1) begin
						fast_val = r_q[0] ? '1 : W'(1);
					end else begin
						needs_iter = 1'b1;
						iter_pow   = 1'b1;
					end
				end
				cfa_pkg::OP_AND: fast_val = l_q & r_q;
				cfa_pkg::OP_OR:  fast_val = l_q | r_q;
				cfa_pkg::OP_XOR: fast_val = l_q ^ r_q;
				cfa_pkg::OP_SHL: begin
					if (bad_shift) begin
						fast_stat = cfa_pkg::STAT_UNDEF;
					end else if (shl_w[2*W-1:W-1] != '0 && shl_w[2*W-1:W-1] != '1) begin
						fast_stat = cfa_pkg::STAT_OVER;
					end else begin
						fast_val = shl_w[W-1:0];
					end
				end
				cfa_pkg::OP_SHR: begin
					if (bad_shift) begin
						fast_stat = cfa_pkg::STAT_UNDEF;
					end else begin
						fast_val = l_q >>> r_q[$clog2(W)-1:0];
					end
				end
				default: fast_stat = cfa_pkg::STAT_UNDEF;
			endcase
		end
	end

	// sign fix-up of the shared unit's magnitudes
	always_comb begin
		wait_val  = '0;
		wait_stat = cfa_pkg::STAT_OK;
		neg       = l_q[W-1] ^ r_q[W-1];
		if (op_q == cfa_pkg::OP_POW) begin
			if (iter_res.over) begin
				wait_stat = cfa_pkg::STAT_OVER;
			end else begin
				wait_val = iter_res.acc;
			end
		end else if (op_q == cfa_pkg::OP_DIV) begin
			// only minimum over minus one leaves the range
			if (!neg && iter_res.quo[W-1]) begin
				wait_stat = cfa_pkg::STAT_OVER;
			end else begin
				wait_val = neg ? (~iter_res.quo + 1'b1) : iter_res.quo;
			end
		end else begin
			wait_val = l_q[W-1] ? (~iter_res.rem + 1'b1) : iter_res.rem;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfa_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cfa_pkg::ST_EXEC;
				end
			end
			cfa_pkg::ST_EXEC: begin
				if (needs_iter) begin
					state_d = cfa_pkg::ST_WAIT;
				end else if (out_free) begin
					state_d = cfa_pkg::ST_IDLE;
				end
			end
			cfa_pkg::ST_WAIT: begin
				if (iter_res.done && out_free) begin
					state_d = cfa_pkg::ST_IDLE;
				end
			end
			default: state_d = cfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = state_q == cfa_pkg::ST_IDLE;
		iter_cmd.start  = (state_q == cfa_pkg::ST_EXEC) && needs_iter;
		iter_cmd.is_pow = iter_pow;
		load_fast       = (state_q == cfa_pkg::ST_EXEC) && !needs_iter && out_free;
		load_wait       = (state_q == cfa_pkg::ST_WAIT) && iter_res.done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_fast || load_wait) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= operation;
			l_q  <= left_value;
			r_q  <= right_value;
			lu_q <= left_undefined;
			ru_q <= right_undefined;
		end
		if (load_fast) begin
			value_q  <= fast_val;
			status_q <= fast_stat;
		end else if (load_wait) begin
			value_q  <= wait_val;
			status_q <= wait_stat;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = value_q;
	assign status       = status_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == cfa_pkg::ST_EXEC)
		else $error("accepted word did not enter execute");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cfa_pkg::STAT_OK |-> result_value == '0)
		else $error("nonzero value with failing status");

	a_wait_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cfa_pkg::ST_WAIT |-> iter_res.busy || iter_res.done)
		else $error("waiting on an idle iter unit");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fast || load_wait) |-> out_free)
		else $error("output register overwritten while full");

endmodule
